// ----- rtl/core/smf_pkg.sv -----
`default_nettype none

package smf_pkg;

	localparam int VALUE_BINS = 64;
	localparam int MAX_ITEMS  = 4096;

	localparam int VALUE_W = 6;
	localparam int FREQ_W  = 13;
	localparam int MODE_W  = 7;

	localparam int BIN_W = $clog2(VALUE_BINS);
	localparam int IDX_W = BIN_W + 1;
	localparam int CNT_W = $clog2(MAX_ITEMS + 1);

	typedef logic [BIN_W-1:0]  bin_t;
	typedef logic [CNT_W-1:0]  count_t;
	typedef logic [MODE_W-1:0] mode_cnt_t;

	localparam count_t MAX_COUNT = CNT_W'(MAX_ITEMS);
	localparam count_t MIN_MODE_FREQ = CNT_W'(2);

	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic               last;
	} item_t;

	typedef struct packed {
		logic [VALUE_W-1:0] mode_value;
		logic               has_mode;
		logic [MODE_W-1:0]  mode_count;
		logic [FREQ_W-1:0]  max_freq;
		logic               last_result;
	} result_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_UPD,
		ST_SCAN
	} state_t;

	// histogram port request from the sequencer
	typedef struct packed {
		logic   wr_en;
		bin_t   wr_addr;
		count_t wr_data;
		logic   rd_en;
		bin_t   rd_addr;
		logic   clr;
	} hist_req_t;

	// flags from the shared compare unit
	typedef struct packed {
		logic eq;
		logic gt;
		logic sat;
	} cmp_stat_t;

	function automatic logic [FREQ_W-1:0] to_freq(count_t c);
		logic [CNT_W+FREQ_W-1:0] w;
		w = {{FREQ_W{1'b0}}, c};
		return w[FREQ_W-1:0];
	endfunction

	function automatic logic [VALUE_W-1:0] bin_to_value(bin_t b);
		logic [BIN_W+VALUE_W-1:0] w;
		w = {{VALUE_W{1'b0}}, b};
		return w[VALUE_W-1:0];
	endfunction

endpackage

`default_nettype wire

// ----- rtl/core/statistical_mode_finder_unit.sv -----
`default_nettype none

// Mode finder for a data set of small unsigned values, one value per start beat,
// the final beat marked by item.last. busy is high for one cycle after each
// accepted beat without last while its histogram bin is read and updated.
// On the last beat the bins are scanned in ascending order through the single
// histogram read port and the shared compare unit: one bin per cycle, ending on
// the final mode. Each mode gives one result beat, marked by result_valid for
// exactly one cycle; the receiver cannot stall and must take every beat.
// A set with highest count below 2 gives a single beat with has_mode low. The
// histogram is empty again after the final result beat of a set, with no
// clearing pass after reset or between sets.
module statistical_mode_finder_unit (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    start,
	input  wire  smf_pkg::item_t   item,
	output logic                   busy,
	output logic                   result_valid,
	output smf_pkg::result_t       result
);

	smf_pkg::state_t     state_q, state_d;
	smf_pkg::bin_t       bin_q;
	logic                in_range_q;
	logic                last_q;
	smf_pkg::count_t     hi_q, hi_d;
	smf_pkg::mode_cnt_t  modes_q, modes_d;
	smf_pkg::mode_cnt_t  emit_q, emit_d;
	logic [smf_pkg::IDX_W-1:0] scan_idx_q, scan_idx_d;
	logic                cmp_vld_s1, cmp_vld_d;
	smf_pkg::bin_t       cmp_bin_s1, cmp_bin_d;
	logic                result_valid_q, res_vld_d;
	smf_pkg::result_t    result_q, res_d;

	smf_pkg::hist_req_t  req;
	smf_pkg::count_t     rd_count;
	smf_pkg::count_t     cmp_res;
	smf_pkg::cmp_stat_t  stat;
	logic                accept;
	logic                item_in_range;
	logic                scan_more;
	logic                upd;
	logic                final_mode;

	smf_hist_ram u_hist (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.rd_count (rd_count)
	);

	smf_cmp_unit u_cmp (
		.operand (rd_count),
		.incr    (state_q == smf_pkg::ST_UPD),
		.highest (hi_q),
		.result  (cmp_res),
		.stat    (stat)
	);

	assign accept        = start && (state_q == smf_pkg::ST_IDLE);
	assign item_in_range = ({1'b0, item.value} <
	                        (smf_pkg::VALUE_W + 1)'(smf_pkg::VALUE_BINS));
	assign scan_more     = (scan_idx_q < smf_pkg::IDX_W'(smf_pkg::VALUE_BINS));
	assign upd           = in_range_q && !stat.sat;
	assign final_mode    = (smf_pkg::mode_cnt_t'(emit_q + smf_pkg::mode_cnt_t'(1)) == modes_q);

	always_comb begin
		state_d    = state_q;
		hi_d       = hi_q;
		modes_d    = modes_q;
		emit_d     = emit_q;
		scan_idx_d = scan_idx_q;
		cmp_vld_d  = 1'b0;
		cmp_bin_d  = cmp_bin_s1;
		res_vld_d  = 1'b0;
		res_d      = result_q;
		req        = '0;

		unique case (state_q)
			smf_pkg::ST_IDLE: begin
				if (start) begin
					req.rd_en   = 1'b1;
					req.rd_addr = item.value[smf_pkg::BIN_W-1:0];
					state_d     = smf_pkg::ST_UPD;
				end
			end

			smf_pkg::ST_UPD: begin
				if (upd) begin
					req.wr_en   = 1'b1;
					req.wr_addr = bin_q;
					req.wr_data = cmp_res;
					if (stat.gt) begin
						hi_d    = cmp_res;
						modes_d = smf_pkg::mode_cnt_t'(1);
					end else if (stat.eq) begin
						modes_d = smf_pkg::mode_cnt_t'(modes_q + smf_pkg::mode_cnt_t'(1));
					end
				end
				state_d = smf_pkg::ST_IDLE;
				if (last_q) begin
					if (hi_d < smf_pkg::MIN_MODE_FREQ) begin
						// no value repeats: one empty-set beat, and the histogram is cleared
						res_vld_d         = 1'b1;
						res_d.mode_value  = '0;
						res_d.has_mode    = 1'b0;
						res_d.mode_count  = '0;
						res_d.max_freq    = smf_pkg::to_freq(hi_d);
						res_d.last_result = 1'b1;
						req.clr           = 1'b1;
						hi_d              = '0;
						modes_d           = '0;
					end else begin
						state_d    = smf_pkg::ST_SCAN;
						scan_idx_d = '0;
						emit_d     = '0;
					end
				end
			end

			smf_pkg::ST_SCAN: begin
				if (scan_more) begin
					req.rd_en   = 1'b1;
					req.rd_addr = scan_idx_q[smf_pkg::BIN_W-1:0];
					scan_idx_d  = smf_pkg::IDX_W'(scan_idx_q + smf_pkg::IDX_W'(1));
					cmp_vld_d   = 1'b1;
					cmp_bin_d   = scan_idx_q[smf_pkg::BIN_W-1:0];
				end
				// read data is registered, so it arrives in the cycle after the address
				if (cmp_vld_s1 && stat.eq) begin
					res_vld_d         = 1'b1;
					res_d.mode_value  = smf_pkg::bin_to_value(cmp_bin_s1);
					res_d.has_mode    = 1'b1;
					res_d.mode_count  = modes_q;
					res_d.max_freq    = smf_pkg::to_freq(hi_q);
					res_d.last_result = final_mode;
					emit_d            = smf_pkg::mode_cnt_t'(emit_q + smf_pkg::mode_cnt_t'(1));
					if (final_mode) begin
						req.clr   = 1'b1;
						hi_d      = '0;
						modes_d   = '0;
						cmp_vld_d = 1'b0;
						state_d   = smf_pkg::ST_IDLE;
					end
				end
			end

			default: begin
				state_d = smf_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= smf_pkg::ST_IDLE;
			hi_q           <= '0;
			modes_q        <= '0;
			emit_q         <= '0;
			scan_idx_q     <= '0;
			cmp_vld_s1     <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			state_q        <= state_d;
			hi_q           <= hi_d;
			modes_q        <= modes_d;
			emit_q         <= emit_d;
			scan_idx_q     <= scan_idx_d;
			cmp_vld_s1     <= cmp_vld_d;
			result_valid_q <= res_vld_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			bin_q      <= item.value[smf_pkg::BIN_W-1:0];
			in_range_q <= item_in_range;
			last_q     <= item.last;
		end
		cmp_bin_s1 <= cmp_bin_d;
		result_q   <= res_d;
	end

	assign busy         = (state_q != smf_pkg::ST_IDLE);
	assign result_valid = result_valid_q;
	assign result       = result_q;

	a_final_then_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.last_result) |=> !result_valid)
		else $error("result beat right after the final beat of a set");

	a_empty_is_final: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !result.has_mode) |-> (result.last_result && result.mode_count == '0))
		else $error("empty mode set beat is not a lone final beat");

	a_mode_count_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.has_mode) |-> (result.mode_count != '0))
		else $error("mode beat with zero mode count");

	a_scan_has_modes: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == smf_pkg::ST_SCAN) |-> (modes_q != '0 && hi_q >= smf_pkg::MIN_MODE_FREQ))
		else $error("scan running without a repeated value");

	a_ascending: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !result.last_result) |=>
		(!result_valid || result.mode_value > $past(result.mode_value)))
		else $error("mode values not ascending");

endmodule

`default_nettype wire

// ----- rtl/core/smf_cmp_unit.sv -----
`default_nettype none

// Shared count unit: optional increment, then compare against the running highest.
module smf_cmp_unit (
	input  wire  smf_pkg::count_t    operand,
	input  wire                      incr,
	input  wire  smf_pkg::count_t    highest,
	output smf_pkg::count_t          result,
	output smf_pkg::cmp_stat_t       stat
);

	smf_pkg::count_t eff;

	always_comb begin
		eff      = incr ? smf_pkg::count_t'(operand + smf_pkg::count_t'(1)) : operand;
		result   = eff;
		stat.sat = (operand == smf_pkg::MAX_COUNT);
		stat.eq  = (eff == highest);
		stat.gt  = (eff > highest);
	end

endmodule

`default_nettype wire

// ----- rtl/core/smf_hist_ram.sv -----
`default_nettype none

// Histogram store: one write and one registered read per cycle.
// Per-bin valid flags make an unwritten bin read as zero and let the whole store clear at once.
module smf_hist_ram (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire  smf_pkg::hist_req_t req,
	output smf_pkg::count_t         rd_count
);

	smf_pkg::count_t                  mem_q [smf_pkg::VALUE_BINS];
	logic [smf_pkg::VALUE_BINS-1:0]   valid_q;
	smf_pkg::count_t                  rd_data_q;
	logic                             rd_valid_q;

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem_q[req.wr_addr] <= req.wr_data;
		end
		if (req.rd_en) begin
			rd_data_q <= mem_q[req.rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (req.clr) begin
				valid_q <= '0;
			end else if (req.wr_en) begin
				valid_q[req.wr_addr] <= 1'b1;
			end
			if (req.rd_en) begin
				rd_valid_q <= valid_q[req.rd_addr];
			end
		end
	end

	assign rd_count = rd_valid_q ? rd_data_q : '0;

endmodule

`default_nettype wire
